@@ hw/rtl/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg: link bring-up sequencer definitions
// Phase, action and event codes plus configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WAITNET    = 4'd1,
    PH_QUERY      = 4'd2,
    PH_CONNECTING = 4'd3,
    PH_CONNWAIT   = 4'd4,
    PH_STARTING   = 4'd5,
    PH_RESUMING   = 4'd6,
    PH_RUNNING    = 4'd7,
    PH_BACKOFF    = 4'd8,
    PH_GAVEUP     = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ACT_IDLE    = 3'd0,
    ACT_WAIT    = 3'd1,
    ACT_STATUS  = 3'd2,
    ACT_CONNECT = 3'd3,
    ACT_START   = 3'd4,
    ACT_RESUME  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    EV_TICK     = 3'd0,
    EV_NETUP    = 3'd1,
    EV_STATUS   = 3'd2,
    EV_CONNACK  = 3'd3,
    EV_STARTACK = 3'd4,
    EV_RESUMED  = 3'd5,
    EV_REINIT   = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    REG_AUTOSTART       = 3'd0,
    REG_STATION_PRESENT = 3'd1,
    REG_POLL_INTERVAL   = 3'd2,
    REG_SETTLE_TIME     = 3'd3,
    REG_BACKOFF_TIME    = 3'd4,
    REG_RETRY_LIMIT     = 3'd5
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_WIDTH = 20;
  localparam int unsigned MS_WIDTH       = 20;
  localparam int unsigned LIMIT_WIDTH    = 9;

  localparam logic [MS_WIDTH-1:0]    POLL_INTERVAL_RST = 20'd3000;
  localparam logic [MS_WIDTH-1:0]    SETTLE_TIME_RST   = 20'd4000;
  localparam logic [MS_WIDTH-1:0]    BACKOFF_TIME_RST  = 20'd5000;
  localparam logic [LIMIT_WIDTH-1:0] RETRY_LIMIT_RST   = 9'd10;

endpackage

`default_nettype wire

@@ hw/rtl/link_bringup_sequencer.sv @@
// ----------------------------------------------------------------------------
// link_bringup_sequencer: ten-phase link bring-up sequencer
// Takes one event per beat and returns the action to take and the new phase.
// ----------------------------------------------------------------------------
// Every accepted event produces exactly one result beat. The decision for an
// event is made in the cycle it is accepted: phase, timers and retry count
// update at that edge, and the result is registered, so one event per cycle
// is sustained while in_stall is low. Results go to an output register
// backed by one skid entry; in_stall rises only when both are full, so an
// event is still taken while one finished result waits downstream.
// Configuration writes are registered; autostart only matters on a re-init
// event.
`default_nettype none

module link_bringup_sequencer #(
  parameter int unsigned TIMER_WIDTH = 21,
  parameter int unsigned RETRY_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [lbs_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  // events
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_event_req,
  input  wire logic        in_link_connected,
  input  wire logic        in_accepted,
  input  wire logic [15:0] in_elapsed_ms,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_action,
  output logic [3:0]       out_phase
);

  localparam int unsigned MSW = lbs_pkg::MS_WIDTH;
  localparam int unsigned CW  = (TIMER_WIDTH > MSW) ? TIMER_WIDTH : MSW;
  localparam int unsigned LW  = (RETRY_WIDTH > 8) ? RETRY_WIDTH : 8;

  // configuration registers
  logic           autostart_r;
  logic           station_present_r;
  logic [MSW-1:0] poll_interval_r;
  logic [MSW-1:0] settle_time_r;
  logic [MSW-1:0] backoff_time_r;
  logic [lbs_pkg::LIMIT_WIDTH-1:0] retry_limit_r;

  // sequencer state
  lbs_pkg::phase_t        phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] phase_timer_r, phase_timer_nxt;
  logic [TIMER_WIDTH-1:0] poll_timer_r, poll_timer_nxt;
  logic [RETRY_WIDTH-1:0] retry_count_r, retry_count_nxt;
  lbs_pkg::action_t       act;

  // output register and skid entry
  logic             out_valid_r;
  lbs_pkg::action_t out_action_r;
  lbs_pkg::phase_t  out_phase_r;
  logic             skid_valid_r;
  lbs_pkg::action_t skid_action_r;
  lbs_pkg::phase_t  skid_phase_r;

  logic in_beat;
  logic out_beat;

  assign in_stall  = skid_valid_r;
  assign in_beat   = in_valid & ~skid_valid_r;
  assign out_beat  = out_valid_r & ~out_stall;
  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_phase  = out_phase_r;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      autostart_r       <= 1'b1;
      station_present_r <= 1'b0;
      poll_interval_r   <= lbs_pkg::POLL_INTERVAL_RST;
      settle_time_r     <= lbs_pkg::SETTLE_TIME_RST;
      backoff_time_r    <= lbs_pkg::BACKOFF_TIME_RST;
      retry_limit_r     <= lbs_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lbs_pkg::REG_AUTOSTART:       autostart_r       <= cfg_data[0];
        lbs_pkg::REG_STATION_PRESENT: station_present_r <= cfg_data[0];
        lbs_pkg::REG_POLL_INTERVAL:   poll_interval_r   <= cfg_data[MSW-1:0];
        lbs_pkg::REG_SETTLE_TIME:     settle_time_r     <= cfg_data[MSW-1:0];
        lbs_pkg::REG_BACKOFF_TIME:    backoff_time_r    <= cfg_data[MSW-1:0];
        lbs_pkg::REG_RETRY_LIMIT:
          retry_limit_r <= cfg_data[lbs_pkg::LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // saturating timer adds, one for each timer
  logic [TIMER_WIDTH:0]   phase_sum, poll_sum;
  logic [TIMER_WIDTH-1:0] phase_acc, poll_acc;
  logic                   settle_done, backoff_done, poll_due;
  logic [RETRY_WIDTH-1:0] retry_inc;
  logic                   give_up;

  always_comb begin
    phase_sum = {1'b0, phase_timer_r} + (TIMER_WIDTH+1)'(in_elapsed_ms);
    poll_sum  = {1'b0, poll_timer_r}  + (TIMER_WIDTH+1)'(in_elapsed_ms);
    phase_acc = phase_sum[TIMER_WIDTH] ? '1 : phase_sum[TIMER_WIDTH-1:0];
    poll_acc  = poll_sum[TIMER_WIDTH]  ? '1 : poll_sum[TIMER_WIDTH-1:0];
    settle_done  = CW'(phase_acc) >= CW'(settle_time_r);
    backoff_done = CW'(phase_acc) >= CW'(backoff_time_r);
    poll_due     = CW'(poll_acc)  >= CW'(poll_interval_r);
    // hold at the top instead of wrapping
    retry_inc = (&retry_count_r) ? retry_count_r : retry_count_r + 1'b1;
    give_up   = ~retry_limit_r[lbs_pkg::LIMIT_WIDTH-1] &&
                (LW'(retry_inc) > LW'(retry_limit_r[7:0]));
  end

  // next phase and action
  always_comb begin
    phase_nxt       = phase_r;
    phase_timer_nxt = phase_timer_r;
    poll_timer_nxt  = poll_timer_r;
    retry_count_nxt = retry_count_r;
    act             = lbs_pkg::ACT_WAIT;

    if (in_event_req == lbs_pkg::EV_REINIT) begin
      phase_nxt       = autostart_r ? lbs_pkg::PH_WAITNET : lbs_pkg::PH_IDLE;
      retry_count_nxt = '0;
      act             = autostart_r ? lbs_pkg::ACT_WAIT : lbs_pkg::ACT_IDLE;
    end else begin
      case (phase_r)
        lbs_pkg::PH_IDLE, lbs_pkg::PH_GAVEUP: begin
          act = lbs_pkg::ACT_IDLE;
        end
        lbs_pkg::PH_WAITNET: begin
          if (in_event_req == lbs_pkg::EV_NETUP) begin
            phase_nxt = lbs_pkg::PH_QUERY;
            act       = lbs_pkg::ACT_STATUS;
          end
        end
        lbs_pkg::PH_QUERY: begin
          if (in_event_req == lbs_pkg::EV_STATUS) begin
            if (in_link_connected) begin
              phase_nxt = lbs_pkg::PH_STARTING;
              act       = lbs_pkg::ACT_START;
            end else begin
              phase_nxt = lbs_pkg::PH_CONNECTING;
              act       = lbs_pkg::ACT_CONNECT;
            end
          end
        end
        lbs_pkg::PH_CONNECTING: begin
          if (in_event_req == lbs_pkg::EV_CONNACK) begin
            phase_nxt = in_accepted ? lbs_pkg::PH_CONNWAIT : lbs_pkg::PH_BACKOFF;
          end
        end
        lbs_pkg::PH_CONNWAIT: begin
          if (in_event_req == lbs_pkg::EV_TICK) begin
            phase_timer_nxt = phase_acc;
            if (settle_done) begin
              phase_nxt = lbs_pkg::PH_STARTING;
              act       = lbs_pkg::ACT_START;
            end
          end
        end
        lbs_pkg::PH_STARTING: begin
          if (in_event_req == lbs_pkg::EV_STARTACK) begin
            if (!in_accepted) begin
              phase_nxt = lbs_pkg::PH_BACKOFF;
            end else if (station_present_r) begin
              phase_nxt = lbs_pkg::PH_RESUMING;
              act       = lbs_pkg::ACT_RESUME;
            end else begin
              phase_nxt = lbs_pkg::PH_RUNNING;
            end
          end
        end
        lbs_pkg::PH_RESUMING: begin
          if (in_event_req == lbs_pkg::EV_RESUMED) begin
            phase_nxt = lbs_pkg::PH_RUNNING;
          end
        end
        lbs_pkg::PH_RUNNING: begin
          if (in_event_req == lbs_pkg::EV_STATUS) begin
            if (!in_link_connected) begin
              phase_nxt = lbs_pkg::PH_BACKOFF;
            end else begin
              retry_count_nxt = '0;
            end
          end else if (in_event_req == lbs_pkg::EV_TICK) begin
            poll_timer_nxt = poll_acc;
            if (poll_due) begin
              poll_timer_nxt = '0;
              act            = lbs_pkg::ACT_STATUS;
            end
          end
        end
        lbs_pkg::PH_BACKOFF: begin
          if (in_event_req == lbs_pkg::EV_TICK) begin
            phase_timer_nxt = phase_acc;
            if (backoff_done) begin
              retry_count_nxt = retry_inc;
              if (give_up) begin
                phase_nxt = lbs_pkg::PH_GAVEUP;
                act       = lbs_pkg::ACT_IDLE;
              end else begin
                phase_nxt = lbs_pkg::PH_CONNECTING;
                act       = lbs_pkg::ACT_CONNECT;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // entering a phase, and re-init, clear both timers
    if (phase_nxt != phase_r || in_event_req == lbs_pkg::EV_REINIT) begin
      phase_timer_nxt = '0;
      poll_timer_nxt  = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= lbs_pkg::PH_WAITNET;
      phase_timer_r <= '0;
      poll_timer_r  <= '0;
      retry_count_r <= '0;
    end else if (in_beat) begin
      phase_r       <= phase_nxt;
      phase_timer_r <= phase_timer_nxt;
      poll_timer_r  <= poll_timer_nxt;
      retry_count_r <= retry_count_nxt;
    end
  end

  // result register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_beat) begin
        out_valid_r  <= in_beat | skid_valid_r;
        skid_valid_r <= 1'b0;
      end else if (in_beat) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_beat) begin
      if (skid_valid_r) begin
        out_action_r <= skid_action_r;
        out_phase_r  <= skid_phase_r;
      end else if (in_beat) begin
        out_action_r <= act;
        out_phase_r  <= phase_nxt;
      end
    end else if (in_beat) begin
      // park the beat while the output is held
      skid_action_r <= act;
      skid_phase_r  <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/link_bringup_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_bringup_sequencer_test: self-checking bench for the bring-up sequencer
// Walks a directed event table, drives the retry count into saturation, then
// runs guided random event streams under several register settings. Every
// result beat is checked against the behavioral sequencer copy or a typed
// row's own answer, with random idling on both the event and the result side.
// ----------------------------------------------------------------------------

module link_bringup_sequencer_test;

  localparam int unsigned TIMER_W = 21;
  localparam int unsigned RETRY_W = 8;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;
  localparam logic [lbs_pkg::MS_WIDTH-1:0] MS_MAX = '1;
  localparam logic [lbs_pkg::LIMIT_WIDTH-1:0] LIMIT_UNLIMITED = 9'h1FF;
  localparam logic [lbs_pkg::LIMIT_WIDTH-1:0] LIMIT_TOP = 9'd254;
  localparam logic [2:0] EV_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int SAT_RETRIES = 260;

  typedef struct packed {
    lbs_pkg::action_t act;
    lbs_pkg::phase_t  ph;
  } answer_t;

  typedef struct {
    logic [2:0]       ev;
    logic             conn;
    logic             ok;
    logic [15:0]      dt;
    bit               typed;
    lbs_pkg::action_t act;
    lbs_pkg::phase_t  ph;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  lbs_pkg::cfg_reg_t cfg_index;
  logic [lbs_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_event_req;
  logic        in_link_connected;
  logic        in_accepted;
  logic [15:0] in_elapsed_ms;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_action;
  logic [3:0]  out_phase;

  // sequencer copy: registers and state
  logic                            c_autostart;
  logic                            c_station;
  logic [lbs_pkg::MS_WIDTH-1:0]    c_poll;
  logic [lbs_pkg::MS_WIDTH-1:0]    c_settle;
  logic [lbs_pkg::MS_WIDTH-1:0]    c_backoff;
  logic [lbs_pkg::LIMIT_WIDTH-1:0] c_limit;
  lbs_pkg::phase_t                 m_phase;
  logic [TIMER_W-1:0]              m_ptimer;
  logic [TIMER_W-1:0]              m_poll;
  logic [RETRY_W-1:0]              m_retry;

  answer_t          answer_q[$];
  bit               row_typed;
  lbs_pkg::action_t row_act;
  lbs_pkg::phase_t  row_ph;
  bit               quiet;
  int               mismatches;
  int               idle_cycles;

  stim_row_t directed_rows [25] = '{
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd0, 1'b1, lbs_pkg::ACT_WAIT, lbs_pkg::PH_WAITNET},
    '{EV_UNUSED, 1'b1, 1'b1, 16'hFFFF, 1'b1, lbs_pkg::ACT_WAIT, lbs_pkg::PH_WAITNET},
    '{lbs_pkg::EV_STATUS, 1'b1, 1'b0, 16'd17, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_NETUP, 1'b0, 1'b0, 16'd0, 1'b1, lbs_pkg::ACT_STATUS, lbs_pkg::PH_QUERY},
    '{lbs_pkg::EV_TICK, 1'b1, 1'b1, 16'd500, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_STATUS, 1'b0, 1'b1, 16'd0, 1'b1,
      lbs_pkg::ACT_CONNECT, lbs_pkg::PH_CONNECTING},
    '{lbs_pkg::EV_CONNACK, 1'b0, 1'b1, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd3999, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd1, 1'b1, lbs_pkg::ACT_START, lbs_pkg::PH_STARTING},
    '{lbs_pkg::EV_STARTACK, 1'b1, 1'b0, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'hFFFF, 1'b1,
      lbs_pkg::ACT_CONNECT, lbs_pkg::PH_CONNECTING},
    '{lbs_pkg::EV_CONNACK, 1'b1, 1'b0, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd4999, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd1, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_CONNACK, 1'b0, 1'b1, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'hFFFF, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_STARTACK, 1'b0, 1'b1, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd2999, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd1, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_STATUS, 1'b1, 1'b0, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_RESUMED, 1'b1, 1'b1, 16'd9, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_STATUS, 1'b0, 1'b0, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_REINIT, 1'b1, 1'b1, 16'hFFFF, 1'b1,
      lbs_pkg::ACT_WAIT, lbs_pkg::PH_WAITNET},
    '{lbs_pkg::EV_NETUP, 1'b1, 1'b1, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE},
    '{lbs_pkg::EV_STATUS, 1'b1, 1'b0, 16'd0, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE}
  };

  link_bringup_sequencer #(
    .TIMER_WIDTH(TIMER_W),
    .RETRY_WIDTH(RETRY_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_event_req      (in_event_req),
    .in_link_connected (in_link_connected),
    .in_accepted       (in_accepted),
    .in_elapsed_ms     (in_elapsed_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_phase         (out_phase)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                  input logic [15:0] b);
    logic [TIMER_W:0] s;
    s = a + b;
    return (s > TIMER_MAX) ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

  function automatic void enter_phase(input lbs_pkg::phase_t p);
    m_phase  = p;
    m_ptimer = '0;
    m_poll   = '0;
  endfunction

  task automatic step_sequencer(input logic [2:0] ev, input logic conn, input logic ok,
                                input logic [15:0] dt, output lbs_pkg::action_t act);
    act = lbs_pkg::ACT_WAIT;
    if (ev == lbs_pkg::EV_REINIT) begin
      m_ptimer = '0;
      m_poll   = '0;
      m_retry  = '0;
      m_phase  = c_autostart ? lbs_pkg::PH_WAITNET : lbs_pkg::PH_IDLE;
      act      = (m_phase == lbs_pkg::PH_IDLE) ? lbs_pkg::ACT_IDLE : lbs_pkg::ACT_WAIT;
    end else begin
      case (m_phase)
        lbs_pkg::PH_IDLE, lbs_pkg::PH_GAVEUP: begin
          act = lbs_pkg::ACT_IDLE;
        end
        lbs_pkg::PH_WAITNET: begin
          if (ev == lbs_pkg::EV_NETUP) begin
            enter_phase(lbs_pkg::PH_QUERY);
            act = lbs_pkg::ACT_STATUS;
          end
        end
        lbs_pkg::PH_QUERY: begin
          if (ev == lbs_pkg::EV_STATUS) begin
            if (conn) begin
              enter_phase(lbs_pkg::PH_STARTING);
              act = lbs_pkg::ACT_START;
            end else begin
              enter_phase(lbs_pkg::PH_CONNECTING);
              act = lbs_pkg::ACT_CONNECT;
            end
          end
        end
        lbs_pkg::PH_CONNECTING: begin
          if (ev == lbs_pkg::EV_CONNACK) begin
            enter_phase(ok ? lbs_pkg::PH_CONNWAIT : lbs_pkg::PH_BACKOFF);
          end
        end
        lbs_pkg::PH_CONNWAIT: begin
          if (ev == lbs_pkg::EV_TICK) begin
            m_ptimer = sat_add(m_ptimer, dt);
            if (m_ptimer >= c_settle) begin
              enter_phase(lbs_pkg::PH_STARTING);
              act = lbs_pkg::ACT_START;
            end
          end
        end
        lbs_pkg::PH_STARTING: begin
          if (ev == lbs_pkg::EV_STARTACK) begin
            if (!ok) begin
              enter_phase(lbs_pkg::PH_BACKOFF);
            end else if (c_station) begin
              enter_phase(lbs_pkg::PH_RESUMING);
              act = lbs_pkg::ACT_RESUME;
            end else begin
              enter_phase(lbs_pkg::PH_RUNNING);
            end
          end
        end
        lbs_pkg::PH_RESUMING: begin
          if (ev == lbs_pkg::EV_RESUMED) begin
            enter_phase(lbs_pkg::PH_RUNNING);
          end
        end
        lbs_pkg::PH_RUNNING: begin
          if (ev == lbs_pkg::EV_STATUS) begin
            if (!conn) begin
              enter_phase(lbs_pkg::PH_BACKOFF);
            end else begin
              m_retry = '0;
            end
          end else if (ev == lbs_pkg::EV_TICK) begin
            m_poll = sat_add(m_poll, dt);
            if (m_poll >= c_poll) begin
              m_poll = '0;
              act = lbs_pkg::ACT_STATUS;
            end
          end
        end
        lbs_pkg::PH_BACKOFF: begin
          if (ev == lbs_pkg::EV_TICK) begin
            m_ptimer = sat_add(m_ptimer, dt);
            if (m_ptimer >= c_backoff) begin
              if (m_retry != RETRY_MAX) begin
                m_retry = m_retry + 1'b1;
              end
              // negative limit: retry forever
              if (!c_limit[lbs_pkg::LIMIT_WIDTH-1] && {1'b0, m_retry} > c_limit) begin
                enter_phase(lbs_pkg::PH_GAVEUP);
                act = lbs_pkg::ACT_IDLE;
              end else begin
                enter_phase(lbs_pkg::PH_CONNECTING);
                act = lbs_pkg::ACT_CONNECT;
              end
            end
          end
        end
        default: begin
          act = lbs_pkg::ACT_WAIT;
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // result check and event prediction, both at the accepting edge
  always @(posedge clk) begin
    answer_t          want;
    lbs_pkg::action_t act;
    bit               moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: action %0d phase %0d",
                                    out_action, out_phase));
        end else begin
          want = answer_q.pop_front();
          if (out_action !== want.act) begin
            report_mismatch($sformatf("action %0d, expected %0d", out_action, want.act));
          end
          if (out_phase !== want.ph) begin
            report_mismatch($sformatf("phase %0d, expected %0d", out_phase, want.ph));
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        step_sequencer(in_event_req, in_link_connected, in_accepted, in_elapsed_ms, act);
        if (row_typed) begin
          answer_q.push_back('{row_act, row_ph});
        end else begin
          answer_q.push_back('{act, m_phase});
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("[%0t] no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side backpressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 15) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(input logic [2:0] ev, input logic conn, input logic ok,
                           input logic [15:0] dt, input bit typed,
                           input lbs_pkg::action_t act, input lbs_pkg::phase_t ph);
    in_event_req      = ev;
    in_link_connected = conn;
    in_accepted       = ok;
    in_elapsed_ms     = dt;
    row_typed         = typed;
    row_act           = act;
    row_ph            = ph;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic send_event(input logic [2:0] ev, input logic conn, input logic ok,
                            input logic [15:0] dt);
    sender_gap();
    send_item(ev, conn, ok, dt, 1'b0, lbs_pkg::ACT_IDLE, lbs_pkg::PH_IDLE);
  endtask

  // hold events off until every result is back
  task automatic drain();
    in_valid = 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input lbs_pkg::cfg_reg_t idx,
                           input logic [lbs_pkg::CFG_DATA_WIDTH-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      lbs_pkg::REG_AUTOSTART:       c_autostart = val[0];
      lbs_pkg::REG_STATION_PRESENT: c_station   = val[0];
      lbs_pkg::REG_POLL_INTERVAL:   c_poll      = val[lbs_pkg::MS_WIDTH-1:0];
      lbs_pkg::REG_SETTLE_TIME:     c_settle    = val[lbs_pkg::MS_WIDTH-1:0];
      lbs_pkg::REG_BACKOFF_TIME:    c_backoff   = val[lbs_pkg::MS_WIDTH-1:0];
      lbs_pkg::REG_RETRY_LIMIT:     c_limit     = val[lbs_pkg::LIMIT_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input logic as, input logic st, input logic [19:0] poll,
                                input logic [19:0] settle, input logic [19:0] back,
                                input logic [lbs_pkg::LIMIT_WIDTH-1:0] lim);
    logic [lbs_pkg::CFG_DATA_WIDTH-1:0] vals [6];
    vals[lbs_pkg::REG_AUTOSTART]       = {19'd0, as};
    vals[lbs_pkg::REG_STATION_PRESENT] = {19'd0, st};
    vals[lbs_pkg::REG_POLL_INTERVAL]   = poll;
    vals[lbs_pkg::REG_SETTLE_TIME]     = settle;
    vals[lbs_pkg::REG_BACKOFF_TIME]    = back;
    vals[lbs_pkg::REG_RETRY_LIMIT]     = {11'd0, lim};
    for (int i = 0; i < 6; i++) begin
      write_reg(lbs_pkg::cfg_reg_t'(i), vals[i]);
    end
  endtask

  function automatic logic [lbs_pkg::MS_WIDTH-1:0] pick_span();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) begin
      return MS_MAX;
    end else if (r == 1) begin
      return '0;
    end
    return lbs_pkg::MS_WIDTH'($urandom_range(0, 12000));
  endfunction

  function automatic logic [lbs_pkg::LIMIT_WIDTH-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return LIMIT_UNLIMITED;
    end else if (r == 2) begin
      return LIMIT_TOP;
    end
    return lbs_pkg::LIMIT_WIDTH'($urandom_range(0, 4));
  endfunction

  // mostly the event the current phase waits for, with random content
  task automatic pick_event(output logic [2:0] ev, output logic conn, output logic ok,
                            output logic [15:0] dt);
    int r;
    conn = $urandom_range(0, 1);
    ok   = $urandom_range(0, 1);
    r    = $urandom_range(0, 9);
    if (r == 0) begin
      dt = '0;
    end else if (r == 1) begin
      dt = '1;
    end else if (r < 5) begin
      dt = 16'($urandom);
    end else begin
      dt = 16'($urandom_range(0, 3000));
    end
    ev = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) begin
      case (m_phase)
        lbs_pkg::PH_WAITNET:    ev = lbs_pkg::EV_NETUP;
        lbs_pkg::PH_QUERY:      ev = lbs_pkg::EV_STATUS;
        lbs_pkg::PH_CONNECTING: begin
          ev = lbs_pkg::EV_CONNACK;
          ok = ($urandom_range(0, 3) != 0);
        end
        lbs_pkg::PH_CONNWAIT:   ev = lbs_pkg::EV_TICK;
        lbs_pkg::PH_STARTING:   begin
          ev = lbs_pkg::EV_STARTACK;
          ok = ($urandom_range(0, 3) != 0);
        end
        lbs_pkg::PH_RESUMING:   ev = lbs_pkg::EV_RESUMED;
        lbs_pkg::PH_RUNNING:    begin
          if ($urandom_range(0, 4) == 0) begin
            ev   = lbs_pkg::EV_STATUS;
            conn = ($urandom_range(0, 3) != 0);
          end else begin
            ev = lbs_pkg::EV_TICK;
          end
        end
        lbs_pkg::PH_BACKOFF:    ev = lbs_pkg::EV_TICK;
        default:                ev = lbs_pkg::EV_REINIT;
      endcase
    end
  endtask

  initial begin
    logic [2:0]  ev;
    logic        conn;
    logic        ok;
    logic [15:0] dt;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = lbs_pkg::REG_AUTOSTART;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_event_req      = lbs_pkg::EV_TICK;
    in_link_connected = 1'b0;
    in_accepted       = 1'b0;
    in_elapsed_ms     = '0;
    row_typed         = 1'b0;
    row_act           = lbs_pkg::ACT_IDLE;
    row_ph            = lbs_pkg::PH_IDLE;
    quiet             = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    c_autostart       = 1'b1;
    c_station         = 1'b0;
    c_poll            = lbs_pkg::POLL_INTERVAL_RST;
    c_settle          = lbs_pkg::SETTLE_TIME_RST;
    c_backoff         = lbs_pkg::BACKOFF_TIME_RST;
    c_limit           = lbs_pkg::RETRY_LIMIT_RST;
    m_phase           = lbs_pkg::PH_WAITNET;
    m_ptimer          = '0;
    m_poll            = '0;
    m_retry           = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      sender_gap();
      send_item(directed_rows[i].ev, directed_rows[i].conn, directed_rows[i].ok,
                directed_rows[i].dt, directed_rows[i].typed, directed_rows[i].act,
                directed_rows[i].ph);
    end
    drain();

    // push the retry count into saturation with unlimited retries, then cap the limit
    apply_settings(1'b1, 1'b0, lbs_pkg::POLL_INTERVAL_RST, '0, '0, LIMIT_UNLIMITED);
    send_event(lbs_pkg::EV_REINIT, 1'b0, 1'b0, 16'd0);
    send_event(lbs_pkg::EV_NETUP, 1'b0, 1'b0, 16'd0);
    send_event(lbs_pkg::EV_STATUS, 1'b0, 1'b0, 16'd0);
    repeat (SAT_RETRIES) begin
      send_event(lbs_pkg::EV_CONNACK, $urandom_range(0, 1), 1'b0, 16'($urandom));
      send_event(lbs_pkg::EV_TICK, $urandom_range(0, 1), $urandom_range(0, 1),
                 16'($urandom));
    end
    drain();
    write_reg(lbs_pkg::REG_RETRY_LIMIT, {11'd0, LIMIT_TOP});
    send_event(lbs_pkg::EV_CONNACK, 1'b0, 1'b0, 16'd0);
    send_item(lbs_pkg::EV_TICK, 1'b0, 1'b0, 16'd0, 1'b1,
              lbs_pkg::ACT_IDLE, lbs_pkg::PH_GAVEUP);
    send_item(lbs_pkg::EV_TICK, 1'b1, 1'b1, 16'hFFFF, 1'b1,
              lbs_pkg::ACT_IDLE, lbs_pkg::PH_GAVEUP);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_settings(1'b1, 1'b1, '0, '0, '0, '0);
        1: apply_settings(1'b1, 1'b0, MS_MAX, MS_MAX, MS_MAX, LIMIT_TOP);
        2: apply_settings(1'b0, 1'b1, 20'd100, 20'd200, 20'd300, LIMIT_UNLIMITED);
        default: apply_settings($urandom_range(0, 4) != 0, $urandom_range(0, 1),
                                pick_span(), pick_span(), pick_span(), pick_limit());
      endcase
      // no idling over the closing stretch
      if (p >= 8) begin
        quiet = 1'b1;
      end
      send_event(lbs_pkg::EV_REINIT, $urandom_range(0, 1), $urandom_range(0, 1),
                 16'($urandom));
      repeat (40) begin
        pick_event(ev, conn, ok, dt);
        send_event(ev, conn, ok, dt);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
